@@ sv/gf2m_inverse_euclid_core_assert.svh @@
// Assertion shorthands for the inversion core.
// Both sample on i_clk and are switched off while i_rst_n is low.
`ifndef GF2M_INVERSE_EUCLID_CORE_ASSERT_SVH
`define GF2M_INVERSE_EUCLID_CORE_ASSERT_SVH

// Same-cycle implication.
`define GF2M_INV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GF2M_INV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/gf2m_inv_pkg.sv @@
`default_nettype none

package gf2m_inv_pkg;

    localparam int unsigned GF2M_INV_FIELD_DEGREE = 10;

    // x^10 + x^3 + 1
    localparam logic [10:0] GF2M_INV_RESET_POLY = 11'd1033;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

`default_nettype wire

@@ sv/gf2m_inverse_euclid_core.sv @@
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   i_element
// output    out        o_valid / i_ready   o_inverse, o_invertible
// config    in         i_cfg_we            i_field_polynomial
//
// One element at a time: a load, then one shift-and-XOR or swap step per cycle
// in a single reduction unit, with no overlap between elements in the loop.
// The loop ends when the second remainder reaches zero; the result goes to an output
// register, so the next element can be taken while a result waits for i_ready.
// If the output register is still full at the end of the loop, the core holds there.
// Reset (synchronous, active low) loads x^10+x^3+1 and empties the core.
`default_nettype none

`include "gf2m_inverse_euclid_core_assert.svh"

module gf2m_inverse_euclid_core #(
    parameter int unsigned FIELD_DEGREE = gf2m_inv_pkg::GF2M_INV_FIELD_DEGREE
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [FIELD_DEGREE:0]   i_field_polynomial,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [FIELD_DEGREE-1:0] i_element,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [FIELD_DEGREE-1:0]      o_inverse,
    output logic                         o_invertible
);

    import gf2m_inv_pkg::*;

    localparam int unsigned PW = FIELD_DEGREE + 1;
    localparam int unsigned XW = FIELD_DEGREE;
    localparam int unsigned DW = $clog2(FIELD_DEGREE + 1);

    // Highest set bit; zero input gives zero (callers test for zero separately).
    function automatic logic [DW-1:0] f_degree(input logic [PW-1:0] v);
        logic [DW-1:0] d;
        d = '0;
        for (int i = 0; i < PW; i++) begin
            if (v[i]) begin
                d = DW'(i);
            end
        end
        return d;
    endfunction

    t_state          r_state, n_state;
    logic [PW-1:0]   r_poly;
    logic [PW-1:0]   r_r0, n_r0;
    logic [PW-1:0]   r_r1, n_r1;
    logic [XW-1:0]   r_x0, n_x0;
    logic [XW-1:0]   r_x1, n_x1;
    logic            r_out_valid, n_out_valid;
    logic [XW-1:0]   r_inverse, n_inverse;
    logic            r_invertible, n_invertible;

    logic [DW-1:0]   w_deg0;
    logic [DW-1:0]   w_deg1;
    logic [DW-1:0]   w_shift;
    logic            w_reduce;

    assign w_deg0   = f_degree(r_r0);
    assign w_deg1   = f_degree(r_r1);
    assign w_shift  = w_deg0 - w_deg1;
    assign w_reduce = (r_r0 != '0) && (w_deg0 >= w_deg1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_poly      <= PW'(GF2M_INV_RESET_POLY);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_poly <= i_field_polynomial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_r0         <= n_r0;
        r_r1         <= n_r1;
        r_x0         <= n_x0;
        r_x1         <= n_x1;
        r_inverse    <= n_inverse;
        r_invertible <= n_invertible;
    end

    always_comb begin
        n_state      = r_state;
        n_r0         = r_r0;
        n_r1         = r_r1;
        n_x0         = r_x0;
        n_x1         = r_x1;
        n_out_valid  = r_out_valid;
        n_inverse    = r_inverse;
        n_invertible = r_invertible;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_r0    = r_poly;
                    n_r1    = {1'b0, i_element};
                    n_x0    = '0;
                    n_x1    = XW'(1);
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_r1 == '0) begin
                    // hold until the output register is free
                    if (!r_out_valid || i_ready) begin
                        n_out_valid = 1'b1;
                        if (r_r0 == PW'(1)) begin
                            n_inverse    = r_x0;
                            n_invertible = 1'b1;
                        end else begin
                            n_inverse    = '0;
                            n_invertible = 1'b0;
                        end
                        n_state = ST_IDLE;
                    end
                end else if (w_reduce) begin
                    // one quotient term: cancel the top bit of r0
                    n_r0 = r_r0 ^ (r_r1 << w_shift);
                    n_x0 = r_x0 ^ (r_x1 << w_shift);
                end else begin
                    // division done: remainder becomes the new divisor
                    n_r0 = r_r1;
                    n_r1 = r_r0;
                    n_x0 = r_x1;
                    n_x1 = r_x0;
                end
            end
        endcase
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_inverse    = r_inverse;
    assign o_invertible = r_invertible;

    `GF2M_INV_ASSERT_NXT(a_load_element, i_valid && o_ready, r_state == ST_RUN && r_r1[PW-1] == 1'b0 && r_r1[XW-1:0] == $past(i_element), "element not loaded on transfer")
    `GF2M_INV_ASSERT_NXT(a_reduce_drops_degree, r_state == ST_RUN && r_r1 != '0 && w_reduce, r_r0 == '0 || w_deg0 < $past(w_deg0), "reduction step did not lower degree")
    `GF2M_INV_ASSERT_NXT(a_swap_orders_degree, r_state == ST_RUN && r_r1 != '0 && !w_reduce, r_r1 == '0 || w_deg1 < w_deg0, "swap left remainders out of order")
    `GF2M_INV_ASSERT_IMP(a_result_from_run, $rose(r_out_valid), $past(r_state) == ST_RUN && r_state == ST_IDLE, "result appeared outside loop exit")
    `GF2M_INV_ASSERT_IMP(a_inverse_zero_when_none, o_valid && !o_invertible, o_inverse == '0, "nonzero inverse flagged as none")

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    import gf2m_inv_pkg::*;

    localparam int FD         = GF2M_INV_FIELD_DEGREE;
    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        logic [FD-1:0] inverse;
        logic          invertible;
    } t_inv_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [FD:0]   i_field_polynomial = GF2M_INV_RESET_POLY;
    logic          i_valid = 1'b0;
    logic          o_ready;
    logic [FD-1:0] i_element = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic [FD-1:0] o_inverse;
    logic          o_invertible;

    logic [FD-1:0] pending_elements[$];
    t_inv_result   expected_inverses[$];
    logic [FD:0]   field_poly_now = GF2M_INV_RESET_POLY;
    int            fail_count = 0;

    gf2m_inverse_euclid_core #(
        .FIELD_DEGREE(FD)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_field_polynomial(i_field_polynomial),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_element(i_element),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_inverse(o_inverse),
        .o_invertible(o_invertible)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int poly_degree(logic [63:0] v);
        int d;
        d = -1;
        for (int k = 63; k >= 0; k--) begin
            if (v[k] && d < 0) begin
                d = k;
            end
        end
        return d;
    endfunction

    // Extended GCD over GF(2)[x]; the Bezout coefficient of the element is the inverse.
    function automatic t_inv_result predict_inverse(logic [FD:0] poly, logic [FD-1:0] elem);
        logic [63:0] r_prev, r_cur, c_prev, c_cur, quo, rem, prod;
        int          d_den, d_rem, sh, k;
        t_inv_result res;
        r_prev = 64'(poly);
        r_cur  = 64'(elem);
        c_prev = 64'd0;
        c_cur  = 64'd1;
        while (r_cur != 64'd0) begin
            quo   = 64'd0;
            rem   = r_prev;
            d_den = poly_degree(r_cur);
            d_rem = poly_degree(rem);
            while (d_rem >= d_den) begin
                sh    = d_rem - d_den;
                quo  |= 64'd1 << sh;
                rem  ^= r_cur << sh;
                d_rem = poly_degree(rem);
            end
            prod = 64'd0;
            for (k = 0; k < 64; k++) begin
                if (quo[k]) begin
                    prod ^= c_cur << k;
                end
            end
            prod   = c_prev ^ prod;
            r_prev = r_cur;
            r_cur  = rem;
            c_prev = c_cur;
            c_cur  = prod;
        end
        if (r_prev == 64'd1) begin
            res.inverse    = c_prev[FD-1:0];
            res.invertible = 1'b1;
        end else begin
            res.inverse    = '0;
            res.invertible = 1'b0;
        end
        return res;
    endfunction

    // Sender: bursts of items separated by random gaps.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_inverses.push_back(predict_inverse(field_poly_now, i_element));
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_elements.size() > 0) begin
                    i_valid   <= 1'b1;
                    i_element <= pending_elements.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 7) == 0) begin
                        burst_left = 64;
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 8);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random ready pattern, plus one long hold-off to back up the core.
    int          run_left = 0;
    int          hold_left = 0;
    int          results_seen = 0;
    t_inv_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (results_seen == 400) begin
                    hold_left = 300;
                end
                if (expected_inverses.size() == 0) begin
                    $error("unexpected result: inverse=%0h invertible=%0b",
                           o_inverse, o_invertible);
                    fail_count++;
                end else begin
                    want = expected_inverses.pop_front();
                    if (o_inverse !== want.inverse) begin
                        $error("inverse mismatch: expected %0h, actual %0h",
                               want.inverse, o_inverse);
                        fail_count++;
                    end
                    if (o_invertible !== want.invertible) begin
                        $error("invertible mismatch: expected %0b, actual %0b",
                               want.invertible, o_invertible);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        i_ready <= 1'b1;
                        run_left = 100;
                    end
                    1, 2, 3, 4, 5: begin
                        i_ready <= 1'b1;
                        run_left = $urandom_range(0, 7);
                    end
                    default: begin
                        i_ready <= 1'b0;
                        run_left = $urandom_range(0, 5);
                    end
                endcase
            end
        end
    end

    // Watchdog on cycles without any transfer.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_elements.size() != 0 || i_valid || expected_inverses.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_field_poly(logic [FD:0] val);
        @(posedge i_clk);
        i_cfg_we           <= 1'b1;
        i_field_polynomial <= val;
        field_poly_now      = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_random(int n);
        logic [FD-1:0] e;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 15))
                0:       e = '0;
                1:       e = FD'(1);
                2:       e = FD'(1 << $urandom_range(0, FD - 1));
                3:       e = '1;
                default: e = FD'($urandom_range(0, (1 << FD) - 1));
            endcase
            pending_elements.push_back(e);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset polynomial: zero, one, all ones, single terms, alternating bits.
        pending_elements = '{10'h000, 10'h001, 10'h002, 10'h003, 10'h3FF, 10'h200,
                             10'h155, 10'h2AA, 10'h008, 10'h009, 10'h100, 10'h0FF,
                             10'h3FE, 10'h204, 10'h010, 10'h301};
        wait_drained();

        write_field_poly(11'h7FF);
        queue_random(250);
        wait_drained();

        write_field_poly(11'h400);
        queue_random(250);
        wait_drained();

        write_field_poly(GF2M_INV_RESET_POLY);
        queue_random(400);
        wait_drained();

        repeat (3) begin
            write_field_poly((FD + 1)'($urandom_range(1025, 2046)));
            queue_random(250);
            wait_drained();
        end

        // Low-degree polynomial: elements of degree above it get swapped in the first step.
        write_field_poly(11'h00B);
        pending_elements = '{10'h3FF, 10'h200, 10'h00B, 10'h008, 10'h005, 10'h000};
        queue_random(100);
        wait_drained();

        write_field_poly((FD + 1)'($urandom_range(0, 1023)));
        queue_random(150);
        wait_drained();

        repeat (60) @(posedge i_clk);
        if (expected_inverses.size() != 0) begin
            $error("%0d results never arrived", expected_inverses.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
